// ----- design/gss_pkg.sv -----
// shared types, codes and groove table for the groove step sequencer
`default_nettype none
package gss_pkg;

    localparam int TICKS_PER_BEAT = 24;

    localparam logic [4:0] TICK_LAST    = 5'(TICKS_PER_BEAT - 1);
    localparam logic [6:0] RESET_BASE   = 7'd48;
    localparam logic [4:0] RESET_MAXN   = 5'd16;
    localparam logic [2:0] RESET_NSEQ   = 3'd4;

    localparam logic [2:0] EV_CLOCK     = 3'd0;
    localparam logic [2:0] EV_NOTE_ON   = 3'd1;
    localparam logic [2:0] EV_NOTE_OFF  = 3'd2;
    localparam logic [2:0] EV_STARTED   = 3'd3;
    localparam logic [2:0] EV_STOPPED   = 3'd4;
    localparam logic [2:0] EV_CONTINUED = 3'd5;

    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_START   = 3'd1;
    localparam logic [2:0] MODE_STOP    = 3'd2;
    localparam logic [2:0] MODE_CONT    = 3'd3;
    localparam logic [2:0] MODE_QSEQ    = 3'd4;
    localparam logic [2:0] MODE_QBASE   = 3'd5;
    localparam logic [2:0] MODE_WSTEP   = 3'd6;
    localparam logic [2:0] MODE_WATTR   = 3'd7;

    localparam logic [1:0] KIND_NOTE    = 2'd0;
    localparam logic [1:0] KIND_TIE     = 2'd2;

    localparam logic [2:0] GROOVE_NONE  = 3'd7;
    localparam logic [1:0] GATE_NONE    = 2'd3;

    localparam logic CFG_MAX_NOTES = 1'b0;
    localparam logic CFG_NUM_SEQS  = 1'b1;

    typedef enum logic [3:0] {
        OP_TICK,
        OP_START,
        OP_STOP,
        OP_CONT,
        OP_QSEQ,
        OP_QBASE,
        OP_WSTEP,
        OP_WATTR,
        OP_NOP
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ATTR,
        ST_STEP,
        ST_FIRST,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] seq_sel;
        logic [3:0] step_sel;
        logic [1:0] step_kind;
        logic [6:0] note_value;
        logic [7:0] velocity;
        logic [3:0] last_step;
        logic [1:0] gate_mode;
        logic [2:0] groove;
        logic [6:0] base_note;
    } req_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [4:0] tick;
        logic [6:0] note;
        logic [7:0] note_velocity;
        logic       last;
    } res_t;

    typedef struct packed {
        op_t  op;
        req_t req;
    } cmd_t;

    // per groove: step mask, then note-off masks for short, normal, long
    localparam logic [23:0] GROOVE_TAB [0:6][0:3] = '{
        '{24'h000001, 24'h001000, 24'h020000, 24'h400000},
        '{24'h001001, 24'h040040, 24'h100100, 24'h800800},
        '{24'h010101, 24'h101010, 24'h404040, 24'h808080},
        '{24'h010001, 24'h100100, 24'h400800, 24'h804000},
        '{24'h041041, 24'h208208, 24'h410410, 24'h820820},
        '{24'h111111, 24'h444444, 24'h888888, 24'h888888},
        '{24'h101101, 24'h410410, 24'h840840, 24'h880880}
    };

    function automatic logic [23:0] groove_mask(logic [2:0] g, logic [1:0] col);
        logic [23:0] m;
        m = '0;
        if (g != GROOVE_NONE)
        begin
            m = GROOVE_TAB[g][col];
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// ----- design/gss_front.sv -----
// front end: classifies each request into a command for the back end
`default_nettype none
module gss_front #(
    parameter int STEPS = 16,
    parameter int SEQS  = 4
) (
    input  var gss_pkg::req_t req,
    output var gss_pkg::cmd_t cmd
);
    import gss_pkg::*;

    logic seq_ok;
    logic step_ok;

    assign seq_ok  = (int'(req.seq_sel) < SEQS);
    assign step_ok = (int'(req.step_sel) < STEPS);

    always_comb
    begin
        cmd.req = req;
        case (req.mode)
            MODE_TICK:  cmd.op = OP_TICK;
            MODE_START: cmd.op = OP_START;
            MODE_STOP:  cmd.op = OP_STOP;
            MODE_CONT:  cmd.op = OP_CONT;
            MODE_QSEQ:  cmd.op = seq_ok ? OP_QSEQ : OP_NOP;
            MODE_QBASE: cmd.op = OP_QBASE;
            MODE_WSTEP: cmd.op = (seq_ok && step_ok) ? OP_WSTEP : OP_NOP;
            MODE_WATTR: cmd.op = seq_ok ? OP_WATTR : OP_NOP;
            default:    cmd.op = OP_NOP;
        endcase
    end

endmodule
`default_nettype wire

// ----- design/gss_cmd_fifo.sv -----
// two-entry command queue between front and back end
`default_nettype none
module gss_cmd_fifo (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            push,
    input  var gss_pkg::cmd_t push_data,
    output logic           full,
    input  wire            pop,
    output logic           not_empty,
    output var gss_pkg::cmd_t pop_data
);
    import gss_pkg::*;

    cmd_t       mem_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_data  = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push && !full)
        begin
            wptr_next = ~wptr_reg;
        end
        if (pop && not_empty)
        begin
            rptr_next = ~rptr_reg;
        end
        if ((push && !full) && !(pop && not_empty))
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!(push && !full) && (pop && not_empty))
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ----- design/gss_back.sv -----
// back end: transport state, step and attribute memories, result output
`default_nettype none
module gss_back #(
    parameter int STEPS = 16,
    parameter int SEQS  = 4
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            cfg_we,
    input  wire            cfg_index,
    input  wire [4:0]      cfg_data,
    input  wire            cmd_valid,
    input  var gss_pkg::cmd_t cmd,
    output logic           cmd_pop,
    output logic           res_valid,
    input  wire            res_stall,
    output var gss_pkg::res_t res
);
    import gss_pkg::*;

    localparam int AW  = $clog2(SEQS * STEPS);
    localparam int SAW = (SEQS > 1) ? $clog2(SEQS) : 1;

    function automatic logic [3:0] idx_mod(logic [3:0] v);
        logic [6:0] t;
        t = {3'b000, v};
        for (int i = 0; i < 8; i++)
        begin
            if (t >= 7'(STEPS))
            begin
                t = t - 7'(STEPS);
            end
        end
        return t[3:0];
    endfunction

    function automatic logic [1:0] seq_mod(logic [1:0] v);
        logic [4:0] t;
        t = {3'b000, v};
        for (int i = 0; i < 3; i++)
        begin
            if (t >= 5'(SEQS))
            begin
                t = t - 5'(SEQS);
            end
        end
        return t[1:0];
    endfunction

    function automatic logic [AW-1:0] step_addr(logic [1:0] s, logic [3:0] i);
        return AW'(int'(seq_mod(s)) * STEPS + int'(idx_mod(i)));
    endfunction

    function automatic logic [SAW-1:0] attr_addr(logic [1:0] s);
        return SAW'(seq_mod(s));
    endfunction

    // memories, undefined until written
    logic [16:0] step_mem [SEQS * STEPS];
    logic [15:0] attr_mem [SEQS];
    logic [16:0] step_q;
    logic [15:0] attr_q;
    logic [AW-1:0]  step_raddr;
    logic [SAW-1:0] attr_raddr;

    state_t state_reg, state_next;

    logic       running_reg, running_next;
    logic [4:0] tc_reg, tc_next;
    logic [3:0] sidx_reg, sidx_next;
    logic [1:0] cur_reg, cur_next;
    logic [1:0] qseq_reg, qseq_next;
    logic [6:0] tb_reg, tb_next;
    logic [6:0] qb_reg, qb_next;
    logic [6:0] snd_reg, snd_next;
    logic [4:0] maxn_reg, maxn_next;
    logic [2:0] nseq_reg, nseq_next;

    logic       off_hit_reg, off_hit_next;
    logic       step_hit_reg, step_hit_next;
    logic       wrap_reg, wrap_next;
    logic [3:0] nidx_reg, nidx_next;
    logic [1:0] ns_reg, ns_next;
    logic [16:0] w_reg, w_next;

    res_t       rbuf_reg [3];
    res_t       rbuf_next [3];
    logic [1:0] rcnt_reg, rcnt_next;
    logic [1:0] ridx_reg, ridx_next;

    res_t res_reg, res_next;
    logic res_valid_reg, res_valid_next;

    // tick decode from the attribute word
    logic [1:0]  a_gate;
    logic [2:0]  a_grv;
    logic [3:0]  a_last;
    logic [4:0]  t_inc;
    logic        t_wrap;
    logic        a_off_hit;
    logic        a_step_hit;
    logic [23:0] off_mask;
    logic [23:0] step_mask;
    logic [6:0]  first_note;
    logic [6:0]  snd_calc;
    logic        out_free;
    logic [4:0]  tick_inc;

    assign a_gate     = attr_q[5:4];
    assign a_grv      = attr_q[8:6];
    assign a_last     = attr_q[3:0];
    assign t_inc      = {1'b0, sidx_reg} + 5'd1;
    assign t_wrap     = (t_inc > {1'b0, a_last});
    assign off_mask   = groove_mask(a_grv, a_gate + 2'd1);
    assign step_mask  = groove_mask(a_grv, 2'd0);
    assign a_off_hit  = (a_gate != GATE_NONE) && off_mask[tc_reg];
    assign a_step_hit = step_mask[tc_reg];
    assign first_note = attr_q[15:9];
    assign snd_calc   = (w_reg[1:0] == KIND_NOTE) ? (w_reg[8:2] + tb_reg - first_note) : 7'd0;
    assign out_free   = !res_valid_reg || !res_stall;
    assign tick_inc   = (tc_reg == TICK_LAST) ? 5'd0 : tc_reg + 5'd1;

    assign cmd_pop   = (state_reg == ST_IDLE) && cmd_valid;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        step_raddr = step_addr(t_wrap ? qseq_reg : cur_reg, t_wrap ? 4'd0 : t_inc[3:0]);
        attr_raddr = attr_addr((state_reg == ST_STEP) ? ns_reg : cur_reg);
    end

    always_ff @(posedge clk)
    begin
        step_q <= step_mem[step_raddr];
        attr_q <= attr_mem[attr_raddr];
        if (cmd_pop && cmd.op == OP_WSTEP)
        begin
            step_mem[step_addr(cmd.req.seq_sel, cmd.req.step_sel)] <=
                {cmd.req.velocity, cmd.req.note_value, cmd.req.step_kind};
        end
        if (cmd_pop && cmd.op == OP_WATTR)
        begin
            attr_mem[attr_addr(cmd.req.seq_sel)] <=
                {cmd.req.base_note, cmd.req.groove, cmd.req.gate_mode, cmd.req.last_step};
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        OP_TICK:  state_next = running_reg ? ST_ATTR : ST_IDLE;
                        OP_START: state_next = ST_EMIT;
                        OP_STOP:  state_next = ST_EMIT;
                        OP_CONT:  state_next = ST_EMIT;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ATTR:
            begin
                if (a_grv == GROOVE_NONE || (!a_off_hit && !a_step_hit))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (step_hit_reg && step_q[1:0] != KIND_TIE)
                begin
                    state_next = ST_FIRST;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_FIRST:
            begin
                state_next = (snd_calc != 7'd0 || rcnt_reg != 2'd0) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (out_free && ridx_reg == rcnt_reg - 2'd1)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        running_next  = running_reg;
        tc_next       = tc_reg;
        sidx_next     = sidx_reg;
        cur_next      = cur_reg;
        qseq_next     = qseq_reg;
        tb_next       = tb_reg;
        qb_next       = qb_reg;
        snd_next      = snd_reg;
        maxn_next     = maxn_reg;
        nseq_next     = nseq_reg;
        off_hit_next  = off_hit_reg;
        step_hit_next = step_hit_reg;
        wrap_next     = wrap_reg;
        nidx_next     = nidx_reg;
        ns_next       = ns_reg;
        w_next        = w_reg;
        rbuf_next     = rbuf_reg;
        rcnt_next     = rcnt_reg;
        ridx_next     = ridx_reg;
        res_next      = res_reg;
        res_valid_next = res_valid_reg && res_stall;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_NOTES: maxn_next = cfg_data;
                CFG_NUM_SEQS:  nseq_next = cfg_data[2:0];
                default:       maxn_next = maxn_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                rcnt_next = 2'd0;
                ridx_next = 2'd0;
                if (cmd_valid)
                begin
                    case (cmd.op)
                        OP_TICK:
                        begin
                            if (running_reg)
                            begin
                                tc_next = tick_inc;
                                rbuf_next[0] = '{EV_CLOCK, tick_inc, 7'd0, 8'd0, 1'b0};
                                rcnt_next = 2'd1;
                            end
                        end
                        OP_START:
                        begin
                            running_next = 1'b1;
                            cur_next     = qseq_reg;
                            tc_next      = TICK_LAST;
                            snd_next     = 7'd0;
                            sidx_next    = 4'(maxn_reg - 5'd1);
                            rbuf_next[0] = '{EV_STARTED, 5'd0, 7'd0, 8'd0, 1'b0};
                            rcnt_next    = 2'd1;
                        end
                        OP_STOP:
                        begin
                            running_next = 1'b0;
                            rbuf_next[0] = '{EV_NOTE_OFF, 5'd0, snd_reg, 8'd0, 1'b0};
                            rbuf_next[1] = '{EV_STOPPED, 5'd0, 7'd0, 8'd0, 1'b0};
                            rcnt_next    = 2'd2;
                        end
                        OP_CONT:
                        begin
                            running_next = 1'b1;
                            rbuf_next[0] = '{EV_CONTINUED, 5'd0, 7'd0, 8'd0, 1'b0};
                            rcnt_next    = 2'd1;
                        end
                        OP_QSEQ:
                        begin
                            if ({1'b0, cmd.req.seq_sel} < nseq_reg)
                            begin
                                qseq_next = cmd.req.seq_sel;
                            end
                        end
                        OP_QBASE: qb_next = cmd.req.base_note;
                        default:  qb_next = qb_reg;
                    endcase
                end
            end
            ST_ATTR:
            begin
                off_hit_next  = a_off_hit;
                step_hit_next = a_step_hit;
                wrap_next     = t_wrap;
                nidx_next     = t_wrap ? 4'd0 : t_inc[3:0];
                ns_next       = t_wrap ? qseq_reg : cur_reg;
            end
            ST_STEP:
            begin
                w_next = step_q;
                // a tie that follows keeps the note sounding
                if (off_hit_reg && step_q[1:0] != KIND_TIE && snd_reg != 7'd0)
                begin
                    rbuf_next[rcnt_reg] = '{EV_NOTE_OFF, 5'd0, snd_reg, 8'd0, 1'b0};
                    rcnt_next = rcnt_reg + 2'd1;
                end
                if (step_hit_reg)
                begin
                    sidx_next = nidx_reg;
                    cur_next  = ns_reg;
                    if (wrap_reg)
                    begin
                        tb_next = qb_reg;
                    end
                end
            end
            ST_FIRST:
            begin
                snd_next = snd_calc;
                if (snd_calc != 7'd0)
                begin
                    rbuf_next[rcnt_reg] = '{EV_NOTE_ON, 5'd0, snd_calc, w_reg[16:9], 1'b0};
                    rcnt_next = rcnt_reg + 2'd1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    res_next       = rbuf_reg[ridx_reg];
                    res_next.last  = (ridx_reg == rcnt_reg - 2'd1);
                    res_valid_next = 1'b1;
                    ridx_next      = ridx_reg + 2'd1;
                end
            end
            default: ridx_next = 2'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            running_reg   <= 1'b0;
            tc_reg        <= TICK_LAST;
            sidx_reg      <= 4'd15;
            cur_reg       <= 2'd0;
            qseq_reg      <= 2'd0;
            tb_reg        <= RESET_BASE;
            qb_reg        <= RESET_BASE;
            snd_reg       <= 7'd0;
            maxn_reg      <= RESET_MAXN;
            nseq_reg      <= RESET_NSEQ;
            rcnt_reg      <= 2'd0;
            ridx_reg      <= 2'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            running_reg   <= running_next;
            tc_reg        <= tc_next;
            sidx_reg      <= sidx_next;
            cur_reg       <= cur_next;
            qseq_reg      <= qseq_next;
            tb_reg        <= tb_next;
            qb_reg        <= qb_next;
            snd_reg       <= snd_next;
            maxn_reg      <= maxn_next;
            nseq_reg      <= nseq_next;
            rcnt_reg      <= rcnt_next;
            ridx_reg      <= ridx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_hit_reg  <= off_hit_next;
        step_hit_reg <= step_hit_next;
        wrap_reg     <= wrap_next;
        nidx_reg     <= nidx_next;
        ns_reg       <= ns_next;
        w_reg        <= w_next;
        rbuf_reg     <= rbuf_next;
        res_reg      <= res_next;
    end

endmodule
`default_nettype wire

// ----- design/groove_step_sequencer_top.sv -----
// Groove step sequencer top level. Requests enter a two-entry command queue and are
// taken up by the back end one at a time. A tick while running is worked out in up
// to four steps (command pop, attribute read, step read, note calculation), and its
// results then leave through the output register one per cycle while the output
// does not stall. Start, continue and stop go from the command pop to the output;
// queue and write requests are done at the pop and give no result. The result
// register lets the next request be taken while a result still waits. Step and
// attribute memories come up undefined and must be written before a sequence is
// played.
`default_nettype none
module groove_step_sequencer_top #(
    parameter int STEPS = 16,
    parameter int SEQS  = 4
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            cfg_we,
    input  wire            cfg_index,
    input  wire [4:0]      cfg_data,
    input  wire            req_valid,
    output logic           req_stall,
    input  var gss_pkg::req_t req,
    output logic           res_valid,
    input  wire            res_stall,
    output var gss_pkg::res_t res
);
    import gss_pkg::*;

    cmd_t front_cmd;
    cmd_t queue_cmd;
    logic queue_full;
    logic queue_valid;
    logic queue_pop;

    assign req_stall = queue_full;

    gss_front #(.STEPS(STEPS), .SEQS(SEQS)) u_front (
        .req (req),
        .cmd (front_cmd)
    );

    gss_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (req_valid),
        .push_data (front_cmd),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_valid),
        .pop_data  (queue_cmd)
    );

    gss_back #(.STEPS(STEPS), .SEQS(SEQS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (queue_valid),
        .cmd       (queue_cmd),
        .cmd_pop   (queue_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule
`default_nettype wire

// ----- design/gss_checker.sv -----
// port-level checks of the sequencer result stream, bound to the top level
`default_nettype none
module gss_checker (
    input wire            clk,
    input wire            rst_n,
    input wire            res_valid,
    input wire            res_stall,
    input var gss_pkg::res_t res
);
    import gss_pkg::*;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result changed");

    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.event_res <= EV_CONTINUED)
        else $error("bad event code");

    a_stopped_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.event_res == EV_STOPPED |-> res.last)
        else $error("stopped event not final");

    a_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.event_res == EV_CLOCK |-> res.tick <= TICK_LAST)
        else $error("tick out of range");

endmodule

bind groove_step_sequencer_top gss_checker u_gss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);
`default_nettype wire

// ----- test/groove_step_sequencer_top_tb.sv -----
// testbench for the groove step sequencer: random and directed requests checked against a predictor
`timescale 1ns / 100ps
`default_nettype none
module groove_step_sequencer_top_tb;
    import gss_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_HOLD = 300;

    // predicts the event stream of the sequencer and checks results in order
    class event_scoreboard;
        bit [4:0]  preset_steps;
        bit [2:0]  num_seqs;
        bit        running;
        bit [4:0]  tick_no;
        bit [3:0]  step_idx;
        bit [1:0]  cur_seq;
        bit [1:0]  q_seq;
        bit [6:0]  base;
        bit [6:0]  q_base;
        bit [6:0]  sounding;
        bit [16:0] steps [64];
        bit [15:0] attrs [4];
        res_t      expected [$];
        res_t      pending [$];
        int        errors;
        int        checked;

        function new();
            preset_steps = 16;
            num_seqs = 4;
            running = 0;
            tick_no = 23;
            step_idx = 15;
            cur_seq = 0;
            q_seq = 0;
            base = 48;
            q_base = 48;
            sounding = 0;
            errors = 0;
            checked = 0;
        endfunction

        function void report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endfunction

        function void set_config(bit idx, bit [4:0] data);
            if (idx == CFG_MAX_NOTES)
                preset_steps = data;
            else
                num_seqs = data[2:0];
        endfunction

        // col 0 is the step mask, 1..3 the note-off masks for short, normal, long
        function bit [23:0] pattern(bit [2:0] g, bit [1:0] col);
            bit [23:0] t [4];
            case (g)
                3'd0: t = '{24'h000001, 24'h001000, 24'h020000, 24'h400000};
                3'd1: t = '{24'h001001, 24'h040040, 24'h100100, 24'h800800};
                3'd2: t = '{24'h010101, 24'h101010, 24'h404040, 24'h808080};
                3'd3: t = '{24'h010001, 24'h100100, 24'h400800, 24'h804000};
                3'd4: t = '{24'h041041, 24'h208208, 24'h410410, 24'h820820};
                3'd5: t = '{24'h111111, 24'h444444, 24'h888888, 24'h888888};
                3'd6: t = '{24'h101101, 24'h410410, 24'h840840, 24'h880880};
                default: t = '{24'h0, 24'h0, 24'h0, 24'h0};
            endcase
            return t[col];
        endfunction

        function void add(bit [2:0] ev, bit [4:0] tk, bit [6:0] nt, bit [7:0] vel);
            res_t r;
            r.event_res = ev;
            r.tick = tk;
            r.note = nt;
            r.note_velocity = vel;
            r.last = 1'b0;
            pending.push_back(r);
        endfunction

        function void advance_tick();
            bit [15:0] a;
            bit [1:0]  gate;
            bit [2:0]  grv;
            bit [4:0]  nidx;
            bit [1:0]  nseq;
            bit [16:0] w;
            bit [23:0] m;
            tick_no = (tick_no == 5'd23) ? 5'd0 : tick_no + 5'd1;
            add(EV_CLOCK, tick_no, 0, 0);
            a = attrs[cur_seq];
            gate = a[5:4];
            grv = a[8:6];
            if (grv == GROOVE_NONE)
                return;
            m = pattern(grv, gate + 2'd1);
            if (gate != GATE_NONE && m[tick_no])
            begin
                nidx = {1'b0, step_idx} + 5'd1;
                nseq = cur_seq;
                if (nidx > {1'b0, a[3:0]})
                begin
                    nidx = 0;
                    nseq = q_seq;
                end
                w = steps[{nseq, nidx[3:0]}];
                // a following tie keeps the note sounding
                if (w[1:0] != KIND_TIE && sounding != 0)
                    add(EV_NOTE_OFF, 0, sounding, 0);
            end
            m = pattern(grv, 2'd0);
            if (m[tick_no])
            begin
                nidx = {1'b0, step_idx} + 5'd1;
                if (nidx > {1'b0, a[3:0]})
                begin
                    nidx = 0;
                    cur_seq = q_seq;
                    base = q_base;
                end
                step_idx = nidx[3:0];
                w = steps[{cur_seq, step_idx}];
                if (w[1:0] == KIND_TIE)
                    return;
                if (w[1:0] == KIND_NOTE)
                    sounding = 7'(w[8:2] + base - attrs[cur_seq][15:9]);
                else
                    sounding = 0;
                if (sounding != 0)
                    add(EV_NOTE_ON, 0, sounding, w[16:9]);
            end
        endfunction

        function void note_request(req_t r);
            res_t x;
            pending.delete();
            case (r.mode)
                MODE_TICK:
                    if (running)
                        advance_tick();
                MODE_START:
                begin
                    running = 1;
                    cur_seq = q_seq;
                    tick_no = 23;
                    sounding = 0;
                    step_idx = 4'(preset_steps - 5'd1);
                    add(EV_STARTED, 0, 0, 0);
                end
                MODE_STOP:
                begin
                    add(EV_NOTE_OFF, 0, sounding, 0);
                    running = 0;
                    add(EV_STOPPED, 0, 0, 0);
                end
                MODE_CONT:
                begin
                    running = 1;
                    add(EV_CONTINUED, 0, 0, 0);
                end
                MODE_QSEQ:
                    if ({1'b0, r.seq_sel} < num_seqs)
                        q_seq = r.seq_sel;
                MODE_QBASE:
                    q_base = r.base_note;
                MODE_WSTEP:
                    steps[{r.seq_sel, r.step_sel}] = {r.velocity, r.note_value, r.step_kind};
                default:
                    attrs[r.seq_sel] = {r.base_note, r.groove, r.gate_mode, r.last_step};
            endcase
            for (int i = 0; i < pending.size(); i++)
            begin
                x = pending[i];
                x.last = (i == pending.size() - 1);
                expected.push_back(x);
            end
        endfunction

        function void check(res_t got);
            res_t want;
            if (expected.size() == 0)
            begin
                report($sformatf("unexpected result event %0d", got.event_res));
                return;
            end
            want = expected.pop_front();
            checked++;
            if (got.event_res != want.event_res)
                report($sformatf("event %0d, want %0d", got.event_res, want.event_res));
            if (got.tick != want.tick)
                report($sformatf("tick %0d, want %0d", got.tick, want.tick));
            if (got.note != want.note)
                report($sformatf("note %0d, want %0d", got.note, want.note));
            if (got.note_velocity != want.note_velocity)
                report($sformatf("velocity %0d, want %0d", got.note_velocity,
                                 want.note_velocity));
            if (got.last != want.last)
                report($sformatf("last %0d, want %0d", got.last, want.last));
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_index = 1'b0;
    logic [4:0] cfg_data = '0;
    logic       req_valid = 1'b0;
    logic       req_stall;
    req_t       req = '0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    res_t       res;

    event_scoreboard sb;
    bit  quiet = 0;
    bit  hold_req = 0;
    int  cycles = 0;
    int  sent = 0;

    groove_step_sequencer_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res(res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // result side: checks and random stall bursts, plus one long hold-off on request
    initial
    begin
        int burst;
        int hold_left;
        burst = 0;
        hold_left = 0;
        sb = new();
        forever
        begin
            @(posedge clk);
            if (res_valid && !res_stall)
                sb.check(res);
            if (hold_req)
            begin
                hold_left = LONG_HOLD;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else if (burst > 0)
            begin
                burst--;
                res_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                burst = $urandom_range(0, 15);
                res_stall <= 1'b1;
            end
            else
                res_stall <= 1'b0;
        end
    end

    task automatic send(req_t r);
        int gap;
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(r);
        sent++;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 16);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering requests and let everything in flight come out
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(bit idx, bit [4:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_config(idx, data);
        @(posedge clk);
    endtask

    function automatic req_t make_req(bit [2:0] mode);
        req_t r;
        r = req_t'({$urandom, $urandom});
        r.mode = mode;
        r.step_kind = 2'($urandom_range(0, 2));
        return r;
    endfunction

    function automatic req_t pick_req();
        int p;
        p = $urandom_range(0, 99);
        if (p < 56)
            return make_req(MODE_TICK);
        else if (p < 62)
            return make_req(MODE_START);
        else if (p < 67)
            return make_req(MODE_STOP);
        else if (p < 72)
            return make_req(MODE_CONT);
        else if (p < 79)
            return make_req(MODE_QSEQ);
        else if (p < 85)
            return make_req(MODE_QBASE);
        else if (p < 93)
            return make_req(MODE_WSTEP);
        return make_req(MODE_WATTR);
    endfunction

    // ticks while stopped do nothing and are not counted
    task automatic random_run(int count);
        req_t r;
        int   done;
        done = 0;
        while (done < count)
        begin
            r = pick_req();
            if (r.mode != MODE_TICK || sb.running)
                done++;
            send(r);
        end
    endtask

    function automatic req_t step_req(bit [1:0] s, bit [3:0] st, bit [1:0] k,
                                      bit [6:0] nv, bit [7:0] v);
        req_t r;
        r = make_req(MODE_WSTEP);
        r.seq_sel = s;
        r.step_sel = st;
        r.step_kind = k;
        r.note_value = nv;
        r.velocity = v;
        return r;
    endfunction

    initial
    begin
        req_t r;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        write_cfg(CFG_MAX_NOTES, 5'd16);
        write_cfg(CFG_NUM_SEQS, 5'd4);

        // fill every step and attribute so nothing unwritten is ever played
        for (int s = 0; s < 4; s++)
        begin
            r = make_req(MODE_WATTR);
            r.seq_sel = 2'(s);
            send(r);
            for (int st = 0; st < 16; st++)
            begin
                r = make_req(MODE_WSTEP);
                r.seq_sel = 2'(s);
                r.step_sel = 4'(st);
                send(r);
            end
        end

        // directed: stop while stopped, note/tie/rest, sixteenth groove
        send(make_req(MODE_STOP));
        r = make_req(MODE_WATTR);
        r.seq_sel = 0;
        r.last_step = 3;
        r.gate_mode = 1;
        r.groove = 4;
        r.base_note = 60;
        send(r);
        send(step_req(0, 0, KIND_NOTE, 7'd127, 8'd255));
        send(step_req(0, 1, KIND_TIE, 7'd0, 8'd0));
        send(step_req(0, 2, 2'd1, 7'd64, 8'd1));
        send(step_req(0, 3, KIND_NOTE, 7'd12, 8'd128));
        r = make_req(MODE_QSEQ);
        r.seq_sel = 0;
        send(r);
        r = make_req(MODE_QBASE);
        r.base_note = 0;
        send(r);
        send(make_req(MODE_START));
        repeat (14) send(make_req(MODE_TICK));
        send(make_req(MODE_STOP));
        send(make_req(MODE_STOP));
        send(make_req(MODE_CONT));
        repeat (3) send(make_req(MODE_TICK));

        random_run(12);
        drain();

        // smallest settings; queue requests above sequence 0 are dropped
        write_cfg(CFG_MAX_NOTES, 5'd1);
        write_cfg(CFG_NUM_SEQS, 5'd1);
        send(make_req(MODE_START));
        hold_req = 1;
        repeat (24) send(make_req(MODE_TICK));
        random_run(10);
        drain();

        write_cfg(CFG_MAX_NOTES, 5'd9);
        write_cfg(CFG_NUM_SEQS, 5'd3);
        random_run(10);
        quiet = 1;
        random_run(10);
        drain();

        $display("Sent %0d requests over three register settings, %0d results checked.",
                 sent, sb.checked);
        $display("Covered all modes, every groove and gate, long output hold-off.");
        if (sb.expected.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected.size()));
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire
